// File: rtl/core/acdr_pkg.sv
`default_nettype none

package acdr_pkg;

    // field kinds reported with each result
    localparam logic [3:0] KIND_VERSION  = 4'd0;
    localparam logic [3:0] KIND_PROFILE  = 4'd1;
    localparam logic [3:0] KIND_COMPAT   = 4'd2;
    localparam logic [3:0] KIND_LEVEL    = 4'd3;
    localparam logic [3:0] KIND_LENSIZE  = 4'd4;
    localparam logic [3:0] KIND_SPSCOUNT = 4'd5;
    localparam logic [3:0] KIND_LENHI    = 4'd6;
    localparam logic [3:0] KIND_LENLO    = 4'd7;
    localparam logic [3:0] KIND_UNITBYTE = 4'd8;
    localparam logic [3:0] KIND_PPSCOUNT = 4'd9;
    localparam logic [3:0] KIND_CHROMA   = 4'd10;
    localparam logic [3:0] KIND_LUMADEP  = 4'd11;
    localparam logic [3:0] KIND_CHROMDEP = 4'd12;
    localparam logic [3:0] KIND_EXTCOUNT = 4'd13;
    localparam logic [3:0] KIND_TRAILING = 4'd14;

    // parameter set classes
    localparam logic [1:0] CLS_SPS = 2'd0;
    localparam logic [1:0] CLS_PPS = 2'd1;
    localparam logic [1:0] CLS_EXT = 2'd2;

    // profiles without the extended trailer
    localparam logic [7:0] PROFILE_BASELINE = 8'd66;
    localparam logic [7:0] PROFILE_MAIN     = 8'd77;
    localparam logic [7:0] PROFILE_EXTENDED = 8'd88;

    // field masks
    localparam logic [7:0] MASK_LENSIZE  = 8'b0000_0011;
    localparam logic [7:0] MASK_SPSCOUNT = 8'b0001_1111;
    localparam logic [7:0] MASK_DEPTH    = 8'b0000_0111;
    localparam logic [7:0] DEPTH_BASE    = 8'd8;

    // one decoded result
    typedef struct packed {
        logic       truncated;
        logic       record_done;
        logic       last_of_unit;
        logic [7:0] unit_index;
        logic [1:0] unit_class;
        logic [7:0] field_value;
        logic [3:0] field_kind;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/acdr_parse.sv
`default_nettype none

module acdr_parse
    import acdr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_accept,
    input  wire logic [7:0] in_byte,
    input  wire logic    first_of_box,
    input  wire logic    last_of_box,
    output result_t      result
);

    // parser phases
    localparam logic [3:0] PH_VERSION  = 4'd0;
    localparam logic [3:0] PH_PROFILE  = 4'd1;
    localparam logic [3:0] PH_COMPAT   = 4'd2;
    localparam logic [3:0] PH_LEVEL    = 4'd3;
    localparam logic [3:0] PH_LENSIZE  = 4'd4;
    localparam logic [3:0] PH_SPSCOUNT = 4'd5;
    localparam logic [3:0] PH_LENHI    = 4'd6;
    localparam logic [3:0] PH_LENLO    = 4'd7;
    localparam logic [3:0] PH_PAYLOAD  = 4'd8;
    localparam logic [3:0] PH_PPSCOUNT = 4'd9;
    localparam logic [3:0] PH_CHROMA   = 4'd10;
    localparam logic [3:0] PH_LUMA     = 4'd11;
    localparam logic [3:0] PH_CDEPTH   = 4'd12;
    localparam logic [3:0] PH_EXTCOUNT = 4'd13;
    localparam logic [3:0] PH_TRAILING = 4'd14;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  units_left;
        logic [15:0] bytes_left;
        logic [7:0]  unit_counter;
        logic [7:0]  profile_seen;
        logic [7:0]  len_hi;
        logic        done_flag;
        logic [1:0]  unit_cls;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase: PH_VERSION, units_left: 8'd0, bytes_left: 16'd0, unit_counter: 8'd0,
        profile_seen: 8'd0, len_hi: 8'd0, done_flag: 1'b0, unit_cls: CLS_SPS
    };

    parse_state_t st_reg;
    parse_state_t st_next;

    // phase after a class of units is finished
    function automatic logic [3:0] section_end(input logic [1:0] cls, input logic [7:0] prof);
        logic plain;
        plain = (prof == PROFILE_BASELINE) || (prof == PROFILE_MAIN)
             || (prof == PROFILE_EXTENDED);
        if (cls == CLS_SPS) begin
            section_end = PH_PPSCOUNT;
        end else if (cls == CLS_PPS && !plain) begin
            section_end = PH_CHROMA;
        end else begin
            section_end = PH_TRAILING;
        end
    endfunction

    // decode one byte and work out the next state
    always_comb begin
        parse_state_t s;
        logic         rdone;
        logic         end_unit;
        logic [7:0]   ul_dec;
        logic [15:0]  bl_dec;
        logic [15:0]  len;

        s        = first_of_box ? STATE_CLEAR : st_reg;
        rdone    = 1'b0;
        end_unit = 1'b0;
        ul_dec   = s.units_left - 8'd1;
        bl_dec   = s.bytes_left - 16'd1;
        len      = {s.len_hi, in_byte};

        result              = '0;
        result.field_kind   = KIND_TRAILING;
        result.field_value  = in_byte;

        unique case (s.phase) inside
            PH_VERSION: begin
                result.field_kind = KIND_VERSION;
                s.phase = PH_PROFILE;
            end
            PH_PROFILE: begin
                result.field_kind = KIND_PROFILE;
                s.profile_seen = in_byte;
                s.phase = PH_COMPAT;
            end
            PH_COMPAT: begin
                result.field_kind = KIND_COMPAT;
                s.phase = PH_LEVEL;
            end
            PH_LEVEL: begin
                result.field_kind = KIND_LEVEL;
                s.phase = PH_LENSIZE;
            end
            PH_LENSIZE: begin
                result.field_kind  = KIND_LENSIZE;
                result.field_value = (in_byte & MASK_LENSIZE) + 8'd1;
                s.phase = PH_SPSCOUNT;
            end
            PH_SPSCOUNT, PH_PPSCOUNT, PH_EXTCOUNT: begin
                s.unit_counter = 8'd0;
                if (s.phase == PH_SPSCOUNT) begin
                    result.field_kind  = KIND_SPSCOUNT;
                    result.field_value = in_byte & MASK_SPSCOUNT;
                    s.unit_cls = CLS_SPS;
                end else if (s.phase == PH_PPSCOUNT) begin
                    result.field_kind = KIND_PPSCOUNT;
                    s.unit_cls = CLS_PPS;
                end else begin
                    result.field_kind = KIND_EXTCOUNT;
                    s.unit_cls = CLS_EXT;
                end
                s.units_left = result.field_value;
                if (result.field_value == 8'd0) begin
                    s.phase = section_end(s.unit_cls, s.profile_seen);
                    rdone   = (s.phase == PH_TRAILING);
                end else begin
                    s.phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                result.field_kind = KIND_LENHI;
                result.unit_class = s.unit_cls;
                result.unit_index = s.unit_counter;
                s.len_hi = in_byte;
                s.phase  = PH_LENLO;
            end
            PH_LENLO: begin
                result.field_kind = KIND_LENLO;
                result.unit_class = s.unit_cls;
                result.unit_index = s.unit_counter;
                s.bytes_left = len;
                if (len == 16'd0) begin
                    end_unit = 1'b1;
                end else begin
                    s.phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                result.field_kind = KIND_UNITBYTE;
                result.unit_class = s.unit_cls;
                result.unit_index = s.unit_counter;
                s.bytes_left = bl_dec;
                end_unit = (bl_dec == 16'd0);
            end
            PH_CHROMA: begin
                result.field_kind  = KIND_CHROMA;
                result.field_value = in_byte & MASK_LENSIZE;
                s.phase = PH_LUMA;
            end
            PH_LUMA: begin
                result.field_kind  = KIND_LUMADEP;
                result.field_value = DEPTH_BASE + (in_byte & MASK_DEPTH);
                s.phase = PH_CDEPTH;
            end
            PH_CDEPTH: begin
                result.field_kind  = KIND_CHROMDEP;
                result.field_value = DEPTH_BASE + (in_byte & MASK_DEPTH);
                s.phase = PH_EXTCOUNT;
            end
            default: begin
                result.field_kind = KIND_TRAILING;
                s.phase = PH_TRAILING;
            end
        endcase

        // closing a unit, and the section when none are left
        if (end_unit) begin
            result.last_of_unit = 1'b1;
            s.unit_counter = s.unit_counter + 8'd1;
            s.units_left   = ul_dec;
            if (ul_dec == 8'd0) begin
                s.phase = section_end(s.unit_cls, s.profile_seen);
                rdone   = (s.phase == PH_TRAILING);
            end else begin
                s.phase = PH_LENHI;
            end
        end

        if (rdone) begin
            s.done_flag = 1'b1;
        end
        result.record_done = rdone;

        // end of box always restarts
        result.truncated = last_of_box && !s.done_flag;
        if (last_of_box) begin
            s = STATE_CLEAR;
        end

        st_next = s;
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_CLEAR;
        end else if (in_accept) begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/acdr_out_skid.sv
`default_nettype none

module acdr_out_skid
    import acdr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  result_t   in_data,
    output logic      in_ready,
    output logic      out_valid,
    output result_t   out_data,
    input  wire logic out_ready
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control: output stage plus one spare entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid) begin
            skid_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/avc_decoder_config_record_parser.sv
// AVC decoder configuration record parser
// Input stream: one record byte per transaction on s_tdata; s_tuser marks the
// first byte of a box (restarts parsing), s_tlast marks the final byte of a box.
// Output stream: one result transaction per input byte, naming the field the
// byte belongs to with its decoded value, parameter set class and index, and
// flags for end of unit, record completion (m_tlast) and early box end.
// Each accepted byte's result is registered in the output stage, or in its
// spare entry under a stall, before it reaches the m_ side. Throughput is one
// byte per cycle while s_tready is high; the phase update and the 16-bit byte
// count decrement sit between the parser state and output registers.
// A two-entry output stage lets a byte be taken while an earlier result waits;
// s_tready falls only once both entries hold results the receiver has not
// taken, and rises again as soon as one is taken. No result is dropped.
// Reset (aresetn low, synchronous) returns the parser to expecting a version
// byte and empties the output stage.
`default_nettype none

module avc_decoder_config_record_parser
    import acdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] first_of_box
    input  wire logic        s_tlast,   // last_of_box
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] field_value, [15:8] unit_index
    output logic [7:0]       m_tuser,   // [3:0] field_kind, [5:4] unit_class,
                                        // [6] last_of_unit, [7] truncated
    output logic             m_tlast    // record_done
);

    logic    accept;
    result_t res;
    result_t res_out;

    assign accept = s_tvalid && s_tready;

    acdr_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (accept),
        .in_byte      (s_tdata),
        .first_of_box (s_tuser),
        .last_of_box  (s_tlast),
        .result       (res)
    );

    acdr_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (res_out),
        .out_ready (m_tready)
    );

    // pack result fields onto the stream
    assign m_tdata = {res_out.unit_index, res_out.field_value};
    assign m_tuser = {res_out.truncated, res_out.last_of_unit,
                      res_out.unit_class, res_out.field_kind};
    assign m_tlast = res_out.record_done;

endmodule

`default_nettype wire

// File: tb/sv/record_field_checker.sv
`timescale 1ns / 100ps

// watches both channels of the record parser, predicts each decoded field
// from the accepted bytes and compares it with what the parser returns
module record_field_checker
    import acdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] first_of_box
    input  wire logic        s_tlast,   // last_of_box
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] field_value, [15:8] unit_index
    input  wire logic [7:0]  m_tuser,   // [3:0] field_kind, [5:4] unit_class,
                                        // [6] last_of_unit, [7] truncated
    input  wire logic        m_tlast,   // record_done
    output int               mismatch_count,
    output int               fields_pending
);

    // where the parser stands within a record
    typedef enum logic [3:0] {
        AT_VERSION, AT_PROFILE, AT_COMPAT, AT_LEVEL, AT_LENSIZE, AT_SPSCOUNT,
        AT_LENHI, AT_LENLO, AT_PAYLOAD, AT_PPSCOUNT, AT_CHROMA, AT_LUMA,
        AT_CDEPTH, AT_EXTCOUNT, AT_TRAILING
    } parse_phase_t;

    parse_phase_t parse_phase;
    logic [7:0]   units_remaining;
    logic [15:0]  payload_remaining;
    logic [7:0]   unit_number;
    logic [7:0]   record_profile;
    logic [7:0]   len_high;
    logic         record_complete;
    logic [1:0]   section_cls;

    result_t expected_fields[$];
    result_t want;
    result_t seen;

    function automatic void clear_record();
        parse_phase       = AT_VERSION;
        units_remaining   = '0;
        payload_remaining = '0;
        unit_number       = '0;
        record_profile    = '0;
        len_high          = '0;
        record_complete   = 1'b0;
        section_cls       = CLS_SPS;
    endfunction

    // leave the current class of units; returns 1 when the record is complete
    function automatic logic close_section();
        if (section_cls == CLS_SPS) begin
            parse_phase = AT_PPSCOUNT;
            return 1'b0;
        end
        if (section_cls == CLS_PPS && record_profile != PROFILE_BASELINE &&
            record_profile != PROFILE_MAIN && record_profile != PROFILE_EXTENDED) begin
            parse_phase = AT_CHROMA;
            return 1'b0;
        end
        parse_phase     = AT_TRAILING;
        record_complete = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic open_section(input logic [1:0] cls, input logic [7:0] count);
        section_cls     = cls;
        units_remaining = count;
        unit_number     = '0;
        if (count == 8'd0)
            return close_section();
        parse_phase = AT_LENHI;
        return 1'b0;
    endfunction

    function automatic logic close_unit();
        unit_number     = unit_number + 8'd1;
        units_remaining = units_remaining - 8'd1;
        if (units_remaining == 8'd0)
            return close_section();
        parse_phase = AT_LENHI;
        return 1'b0;
    endfunction

    // decode one record byte and advance the parse state
    function automatic result_t decode_record_byte(input logic [7:0] b, input logic first,
                                                   input logic last);
        result_t r;
        r = '0;
        r.field_kind  = KIND_TRAILING;
        r.field_value = b;
        if (first)
            clear_record();
        case (parse_phase)
            AT_VERSION: begin
                r.field_kind = KIND_VERSION;
                parse_phase  = AT_PROFILE;
            end
            AT_PROFILE: begin
                r.field_kind   = KIND_PROFILE;
                record_profile = b;
                parse_phase    = AT_COMPAT;
            end
            AT_COMPAT: begin
                r.field_kind = KIND_COMPAT;
                parse_phase  = AT_LEVEL;
            end
            AT_LEVEL: begin
                r.field_kind = KIND_LEVEL;
                parse_phase  = AT_LENSIZE;
            end
            AT_LENSIZE: begin
                r.field_kind  = KIND_LENSIZE;
                r.field_value = (b & MASK_LENSIZE) + 8'd1;
                parse_phase   = AT_SPSCOUNT;
            end
            AT_SPSCOUNT: begin
                r.field_kind    = KIND_SPSCOUNT;
                r.field_value   = b & MASK_SPSCOUNT;
                r.record_done   = open_section(CLS_SPS, b & MASK_SPSCOUNT);
            end
            AT_LENHI: begin
                r.field_kind = KIND_LENHI;
                r.unit_class = section_cls;
                r.unit_index = unit_number;
                len_high     = b;
                parse_phase  = AT_LENLO;
            end
            AT_LENLO: begin
                r.field_kind      = KIND_LENLO;
                r.unit_class      = section_cls;
                r.unit_index      = unit_number;
                payload_remaining = {len_high, b};
                // a zero-length unit ends on its low length byte
                if (payload_remaining == 16'd0) begin
                    r.last_of_unit = 1'b1;
                    r.record_done  = close_unit();
                end else begin
                    parse_phase = AT_PAYLOAD;
                end
            end
            AT_PAYLOAD: begin
                r.field_kind      = KIND_UNITBYTE;
                r.unit_class      = section_cls;
                r.unit_index      = unit_number;
                payload_remaining = payload_remaining - 16'd1;
                if (payload_remaining == 16'd0) begin
                    r.last_of_unit = 1'b1;
                    r.record_done  = close_unit();
                end
            end
            AT_PPSCOUNT: begin
                r.field_kind  = KIND_PPSCOUNT;
                r.record_done = open_section(CLS_PPS, b);
            end
            AT_CHROMA: begin
                // chroma format is a two-bit field like the length size
                r.field_kind  = KIND_CHROMA;
                r.field_value = b & MASK_LENSIZE;
                parse_phase   = AT_LUMA;
            end
            AT_LUMA: begin
                r.field_kind  = KIND_LUMADEP;
                r.field_value = DEPTH_BASE + (b & MASK_DEPTH);
                parse_phase   = AT_CDEPTH;
            end
            AT_CDEPTH: begin
                r.field_kind  = KIND_CHROMDEP;
                r.field_value = DEPTH_BASE + (b & MASK_DEPTH);
                parse_phase   = AT_EXTCOUNT;
            end
            AT_EXTCOUNT: begin
                r.field_kind  = KIND_EXTCOUNT;
                r.record_done = open_section(CLS_EXT, b);
            end
            default: begin
                r.field_kind = KIND_TRAILING;
                parse_phase  = AT_TRAILING;
            end
        endcase
        // box end always returns to the version byte
        if (last) begin
            r.truncated = !record_complete;
            clear_record();
        end
        return r;
    endfunction

    // queue the prediction for one input transaction
    function automatic void queue_field(input result_t r);
        expected_fields.insert(expected_fields.size(), r);
    endfunction

    // predict on every input transaction, compare on every output transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_record();
            expected_fields.delete();
            mismatch_count = 0;
            fields_pending <= 0;
        end else begin
            if (s_tvalid && s_tready)
                queue_field(decode_record_byte(s_tdata, s_tuser, s_tlast));
            if (m_tvalid && m_tready) begin
                seen.field_value  = m_tdata[7:0];
                seen.unit_index   = m_tdata[15:8];
                seen.field_kind   = m_tuser[3:0];
                seen.unit_class   = m_tuser[5:4];
                seen.last_of_unit = m_tuser[6];
                seen.truncated    = m_tuser[7];
                seen.record_done  = m_tlast;
                if (expected_fields.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result transaction: kind %0d value %02h",
                                 seen.field_kind, seen.field_value);
                    mismatch_count++;
                end else begin
                    want = expected_fields.pop_front();
                    if (seen.field_kind !== want.field_kind ||
                        seen.field_value !== want.field_value ||
                        seen.unit_class !== want.unit_class ||
                        seen.unit_index !== want.unit_index ||
                        seen.last_of_unit !== want.last_of_unit ||
                        seen.record_done !== want.record_done ||
                        seen.truncated !== want.truncated) begin
                        if (mismatch_count < 10)
                            $display({"field mismatch: expected kind %0d value %02h cls %0d ",
                                      "idx %0d lou %b done %b trunc %b, got kind %0d ",
                                      "value %02h cls %0d idx %0d lou %b done %b trunc %b"},
                                     want.field_kind, want.field_value, want.unit_class,
                                     want.unit_index, want.last_of_unit, want.record_done,
                                     want.truncated, seen.field_kind, seen.field_value,
                                     seen.unit_class, seen.unit_index, seen.last_of_unit,
                                     seen.record_done, seen.truncated);
                        mismatch_count++;
                    end
                end
            end
            fields_pending <= expected_fields.size();
        end
    end

endmodule

// File: tb/sv/tb_avc_decoder_config_record_parser.sv
`timescale 1ns / 100ps

module tb_avc_decoder_config_record_parser;
    import acdr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int fields_pending;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int receiver_hold = 0;
    bit sender_busy   = 1'b1;
    bit receiver_busy = 1'b1;

    logic [7:0] box_bytes[$];

    avc_decoder_config_record_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    record_field_checker u_field_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .fields_pending (fields_pending)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_avc_decoder_config_record_parser: FAIL");
            $finish;
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = receiver_busy ? $urandom_range(0, 4) : 0;
            if (receiver_hold > 0) begin
                stall         = receiver_hold;
                receiver_hold = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // offer one byte after a random gap and wait for its transaction
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = sender_busy ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (fields_pending != 0);
    endtask

    // add one byte to the end of the box being built
    function automatic void append_byte(input logic [7:0] b);
        box_bytes.insert(box_bytes.size(), b);
    endfunction

    // append a section of units with random lengths and payload
    task automatic add_units(input int units, input int max_len);
        int len;
        for (int u = 0; u < units; u++) begin
            len = (max_len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                           : $urandom_range(0, max_len);
            append_byte(len[15:8]);
            append_byte(len[7:0]);
            repeat (len) append_byte(8'($urandom));
        end
    endtask

    // well-formed record with random field contents
    task automatic build_record(input logic [7:0] profile, input int sps, input int pps,
                                input int ext, input int max_len);
        logic [7:0] rnd;
        box_bytes.delete();
        append_byte(8'($urandom));
        append_byte(profile);
        append_byte(8'($urandom));
        append_byte(8'($urandom));
        append_byte(8'($urandom));
        rnd = 8'($urandom);
        append_byte({rnd[7:5], sps[4:0]});
        add_units(sps, max_len);
        append_byte(pps[7:0]);
        add_units(pps, max_len);
        if (profile != PROFILE_BASELINE && profile != PROFILE_MAIN &&
            profile != PROFILE_EXTENDED) begin
            repeat (3) append_byte(8'($urandom));
            append_byte(ext[7:0]);
            add_units(ext, max_len);
        end
    endtask

    initial begin
        int         pick;
        int         ending;
        int         cut;
        int         record_count;
        bit         mark_last;
        bit         hold_done;
        bit         drain_done;
        bit         wide_done;
        logic [7:0] profile;

        record_count = 0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        wide_done    = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // baseline record: masked counts, one sps, no pps, then a trailing byte
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(PROFILE_BASELINE, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFC, 1'b0, 1'b0);
        send_byte(8'hE1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7E, 1'b0, 1'b1);

        // high profile: zero sps, zero-length pps, extremes of chroma and depths
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'd100, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hE0, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        // restart inside a record, then a box that ends early
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(PROFILE_MAIN, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // random records, mostly well formed, with some noise
        while (bytes_sent < 1000) begin
            record_count++;
            if (record_count % 8 == 0) begin
                sender_busy   = $urandom_range(0, 3) != 0;
                receiver_busy = $urandom_range(0, 3) != 0;
            end
            if (!hold_done && bytes_sent >= 300) begin
                hold_done     = 1'b1;
                sender_busy   = 1'b0;
                receiver_hold = 80;
            end
            if (!drain_done && bytes_sent >= 600) begin
                drain_done = 1'b1;
                drain_results();
            end

            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // noise with random box marks
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0);
            end else begin
                case ($urandom_range(0, 4))
                    0: profile = PROFILE_BASELINE;
                    1: profile = PROFILE_MAIN;
                    2: profile = PROFILE_EXTENDED;
                    3: profile = 8'd100;
                    default: profile = 8'($urandom);
                endcase
                if (!wide_done && bytes_sent >= 450) begin
                    // full pps count of empty units runs the unit index up to 254
                    wide_done = 1'b1;
                    build_record(profile, 31, 255, 2, 0);
                end else begin
                    build_record(profile,
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 3),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                             : $urandom_range(0, 3),
                                 $urandom_range(0, 2), 5);
                end
                ending    = $urandom_range(0, 9);
                mark_last = 1'b1;
                if (ending >= 4 && ending <= 5)
                    repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
                if (ending >= 6 && ending <= 7 && box_bytes.size() > 1) begin
                    cut = int'($urandom_range(1, box_bytes.size() - 1));
                    while (box_bytes.size() > cut) void'(box_bytes.pop_back());
                end
                if (ending == 8)
                    mark_last = 1'b0;
                if (ending == 9) begin
                    append_byte(8'($urandom));
                    mark_last = 1'b0;
                end
                foreach (box_bytes[i])
                    send_byte(box_bytes[i], i == 0,
                              mark_last && i == box_bytes.size() - 1);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && fields_pending == 0)
            $display("tb_avc_decoder_config_record_parser: PASS");
        else
            $display("tb_avc_decoder_config_record_parser: FAIL");
        $finish;
    end

endmodule
